[src/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the stream record table
// Command and status codes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package srt_pkg;

   localparam int unsigned MaxRecordsDefault = 256;
   localparam int unsigned MaxEventsDefault  = 4;

   typedef enum logic [2:0] {
      CMD_APPEND  = 3'd0,
      CMD_SLIDE   = 3'd1,
      CMD_FIND    = 3'd2,
      CMD_GET     = 3'd3,
      CMD_EVENT   = 3'd4,
      CMD_ADVANCE = 3'd5,
      CMD_NOP6    = 3'd6,
      CMD_NOP7    = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_EVFULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_WRITE,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

[src/stream_record_table_top.sv]
// ----------------------------------------------------------------------------
// stream_record_table_top: table of records over a sliding stream window
// Appends, slides with in-order compaction, id search, indexed access,
// per-record event lists and a progress counter.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer marked by        Payload
// request   in         start high, busy low      req_cmd .. req_event_code
// response  out        rsp_valid for one cycle   rsp_status .. rsp_progress
//
// Every command walks through a small sequencer that owns one memory port.
// Append, get, add event and advance pass through the read, evaluate, write
// and done states once before the response strobe. Slide and find visit one
// stored record at a time (read, evaluate, write back), since the single memory
// port and the registered read data allow no overlap; find stops at the first
// hit. busy is high from the transfer until the response strobe. Reset is
// synchronous and clears the count, the id counter and progress; the record
// memory is not cleared, since only positions below the count are ever used.
// The receiver cannot stall.
`default_nettype none
module stream_record_table_top
   import srt_pkg::*;
#(
   parameter int unsigned MAX_RECORDS = MaxRecordsDefault,
   parameter int unsigned MAX_EVENTS  = MaxEventsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [30:0] req_offset,
   input  wire logic [30:0] req_length,
   input  wire logic [7:0]  req_rec_type,
   input  wire logic [30:0] req_amount,
   input  wire logic [31:0] req_key_id,
   input  wire logic [7:0]  req_index,
   input  wire logic [7:0]  req_event_code,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_rec_index,
   output logic [31:0]      rsp_rec_id,
   output logic signed [31:0] rsp_rec_offset,
   output logic [30:0]      rsp_rec_len,
   output logic [7:0]       rsp_rec_kind,
   output logic [2:0]       rsp_event_count,
   output logic [31:0]      rsp_events_packed,
   output logic [8:0]       rsp_rec_count,
   output logic [31:0]      rsp_progress
);

   localparam int unsigned AW = $clog2(MAX_RECORDS);
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
   localparam int unsigned EW = $clog2(MAX_EVENTS + 1);
   localparam int unsigned SHOWN = (MAX_EVENTS < 4) ? MAX_EVENTS : 4;

   // One record row: start, length, id, type, event count, events.
   typedef struct packed {
      logic [31:0]                 start;
      logic [30:0]                 len;
      logic [31:0]                 id;
      logic [7:0]                  kind;
      logic [EW-1:0]               ecnt;
      logic [MAX_EVENTS-1:0][7:0]  ev;
   } row_type;

   row_type mem [MAX_RECORDS];
   row_type rd_ff;

   state_type state_ff, state_in;

   cmd_type     cmd_ff, cmd_in;
   logic [30:0] off_ff, off_in, len_ff, len_in, amt_ff, amt_in;
   logic [7:0]  kind_ff, kind_in, idx_ff, idx_in, evc_ff, evc_in;
   logic [31:0] key_ff, key_in;

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   nid_ff, nid_in, prog_ff, prog_in;
   logic [CW-1:0] scan_ff, scan_in;   // read position
   logic [CW-1:0] kept_ff, kept_in;   // write position during slide

   logic          we;
   logic [AW-1:0] waddr, raddr;
   row_type       wdata;

   logic          hit_ff, hit_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] pos_ff, pos_in;
   row_type       out_ff, out_in;

   logic          idx_ok;
   logic          keep;
   logic signed [32:0] rec_end;

   // Index range check against the held count.
   assign idx_ok = ({{(CW > 8 ? CW - 8 : 0){1'b0}}, idx_ff} < {{(8 > CW ? 8 - CW : 0){1'b0}}, count_ff})
                   && (32'(idx_ff) < 32'(MAX_RECORDS));

   // Signed end of record versus slide amount (33 bits, no overflow).
   assign rec_end = $signed({rd_ff.start[31], rd_ff.start}) + $signed({2'b00, rd_ff.len});
   assign keep    = rec_end > $signed({2'b00, amt_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_READ;
         S_READ: begin
            if ((cmd_ff == CMD_SLIDE || cmd_ff == CMD_FIND) && scan_ff >= count_ff)
               state_in = S_DONE;
            else
               state_in = S_EVAL;
         end
         S_EVAL:  state_in = S_WRITE;
         S_WRITE: begin
            if ((cmd_ff == CMD_SLIDE || (cmd_ff == CMD_FIND && !hit_ff)))
               state_in = S_READ;
            else
               state_in = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      cmd_in = cmd_ff; off_in = off_ff; len_in = len_ff; amt_in = amt_ff;
      kind_in = kind_ff; idx_in = idx_ff; evc_in = evc_ff; key_in = key_ff;
      count_in = count_ff; nid_in = nid_ff; prog_in = prog_ff;
      scan_in = scan_ff; kept_in = kept_ff; hit_in = hit_ff;
      status_in = status_ff; pos_in = pos_ff; out_in = out_ff;
      we = 1'b0; waddr = pos_ff; wdata = rd_ff;
      raddr = AW'(idx_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = cmd_type'(req_cmd);
               off_in = req_offset; len_in = req_length; amt_in = req_amount;
               kind_in = req_rec_type; idx_in = req_index;
               evc_in = req_event_code; key_in = req_key_id;
               scan_in = '0; kept_in = '0; hit_in = 1'b0;
               status_in = ST_OK; out_in = '0; pos_in = '0;
            end
         end
         S_READ: begin
            raddr = (cmd_ff == CMD_SLIDE || cmd_ff == CMD_FIND)
                    ? scan_ff[AW-1:0] : AW'(idx_ff);
            if (cmd_ff == CMD_FIND && scan_ff >= count_ff) status_in = ST_MISS;
            if (cmd_ff == CMD_SLIDE && scan_ff >= count_ff) count_in = kept_ff;
            // Progress drops once per slide, even when the table is empty.
            if (cmd_ff == CMD_SLIDE && scan_ff == '0)
               prog_in = ({1'b0, amt_ff} >= prog_ff) ? '0 : prog_ff - {1'b0, amt_ff};
         end
         S_EVAL: begin
            case (cmd_ff)
               CMD_APPEND: begin
                  if (count_ff >= CW'(MAX_RECORDS)) status_in = ST_FULL;
                  else begin
                     out_in = '0;
                     out_in.start = {1'b0, off_ff}; out_in.len = len_ff;
                     out_in.id = nid_ff; out_in.kind = kind_ff;
                     pos_in = count_ff[AW-1:0]; hit_in = 1'b1;
                  end
               end
               CMD_SLIDE: begin
                  out_in = rd_ff;
                  out_in.start = rd_ff.start - {1'b0, amt_ff};
                  hit_in = keep;
                  pos_in = kept_ff[AW-1:0];
               end
               CMD_FIND: begin
                  if (rd_ff.id == key_ff) begin
                     hit_in = 1'b1; out_in = rd_ff; pos_in = scan_ff[AW-1:0];
                  end
               end
               CMD_GET: begin
                  if (idx_ok) begin
                     hit_in = 1'b1; out_in = rd_ff; pos_in = AW'(idx_ff);
                  end else status_in = ST_MISS;
               end
               CMD_EVENT: begin
                  if (!idx_ok) status_in = ST_MISS;
                  else begin
                     hit_in = 1'b1; out_in = rd_ff; pos_in = AW'(idx_ff);
                     if (32'(rd_ff.ecnt) >= 32'(MAX_EVENTS)) status_in = ST_EVFULL;
                     else begin
                        out_in.ev[rd_ff.ecnt[$clog2(MAX_EVENTS > 1 ? MAX_EVENTS : 2)-1:0]]
                           = evc_ff;
                        out_in.ecnt = rd_ff.ecnt + EW'(1);
                     end
                  end
               end
               CMD_ADVANCE: prog_in = prog_ff + {1'b0, amt_ff};
               default: ;
            endcase
         end
         S_WRITE: begin
            wdata = out_ff; waddr = pos_ff;
            case (cmd_ff)
               CMD_APPEND: if (hit_ff) begin
                  we = 1'b1; count_in = count_ff + CW'(1); nid_in = nid_ff + 32'd1;
               end
               CMD_SLIDE: begin
                  if (hit_ff) begin we = 1'b1; kept_in = kept_ff + CW'(1); end
                  scan_in = scan_ff + CW'(1);
               end
               CMD_FIND: if (!hit_ff) scan_in = scan_ff + CW'(1);
               CMD_EVENT: if (hit_ff && status_ff == ST_OK) we = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; nid_ff <= '0; prog_ff <= '0;
         cmd_ff <= CMD_NOP6;
      end else begin
         state_ff <= state_in; count_ff <= count_in; nid_ff <= nid_in;
         prog_ff <= prog_in; cmd_ff <= cmd_in;
      end
      off_ff <= off_in; len_ff <= len_in; amt_ff <= amt_in; kind_ff <= kind_in;
      idx_ff <= idx_in; evc_ff <= evc_in; key_ff <= key_in; scan_ff <= scan_in;
      kept_ff <= kept_in; hit_ff <= hit_in; status_ff <= status_in;
      pos_ff <= pos_in; out_ff <= out_in;
   end

   // A response names a record only for an ok or event-full status with a hit,
   // and never for a slide.
   logic show;
   logic [31:0] packed_ev;
   always_comb begin
      packed_ev = '0;
      for (int k = 0; k < SHOWN; k++)
         if (32'(out_ff.ecnt) > 32'(k)) packed_ev[8*k +: 8] = out_ff.ev[k];
   end
   assign show = hit_ff && cmd_ff != CMD_SLIDE;

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = state_ff == S_DONE;
   assign rsp_status        = status_ff;
   assign rsp_rec_index     = show ? 8'(pos_ff) : '0;
   assign rsp_rec_id        = show ? out_ff.id : '0;
   assign rsp_rec_offset    = show ? out_ff.start : '0;
   assign rsp_rec_len       = show ? out_ff.len : '0;
   assign rsp_rec_kind      = show ? out_ff.kind : '0;
   assign rsp_event_count   = show ? 3'(out_ff.ecnt) : '0;
   assign rsp_events_packed = show ? packed_ev : '0;
   assign rsp_rec_count     = 9'(count_ff);
   assign rsp_progress      = prog_ff;

   // The count never exceeds the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("record count beyond depth");
   // A response strobe lasts a single cycle.
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");
   // Appends advance the id counter by exactly one.
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && cmd_ff == CMD_APPEND && hit_ff)
      |=> nid_ff == $past(nid_ff) + 32'd1) else $error("id counter slip");

endmodule
`default_nettype wire
